// ----- design/pfa_pkg.sv -----
`default_nettype none
package pfa_pkg;

   // input word
   typedef struct packed {
      logic       req_type;
      logic [7:0] proc_id;
      logic [3:0] pages_needed;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [2:0] status;
      logic [3:0] frames_changed;
      logic [3:0] free_frames;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_FREE_ALLOC = 3'd0,
      ST_FIFO_ALLOC = 3'd1,
      ST_FREED      = 3'd2,
      ST_NOT_FOUND  = 3'd3,
      ST_REJECTED   = 3'd4
   } status_type;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_SCAN,
      S_FIFO_WR,
      S_FREE_RD,
      S_FREE_CHK,
      S_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;
      logic       take;
      logic       fifo_write;
      logic       release_frame;
      logic       idx_inc;
      logic       respond;
      status_type code;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_free_req;
      logic want_zero;
      logic cur_free;
      logic met_next;
      logic idx_last;
      logic owner_match;
      logic any_writes;
      logic rem_last;
   } flag_type;

endpackage
`default_nettype wire

// ----- design/page_frame_allocator_fifo.sv -----
// Sequence from start to rsp_valid: a rejected request goes straight to the finish state; an
// allocate scans frames for free ones and falls back to FIFO replacement when free frames run
// out; a free reads and then checks each frame in turn through the registered owner-table read.
// Throughput: one request at a time; busy drops as the result is registered, so the next
// start is taken in the cycle rsp_valid is high. The receiver cannot stall results.
// Reset: synchronous; every frame free, FIFO pointer at frame 0, no result pending.
`default_nettype none
module page_frame_allocator_fifo #(
   parameter int NUM_FRAMES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire pfa_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   output pfa_pkg::rsp_word_type      rsp_word
);
   import pfa_pkg::*;

   // command word from the sequencer, status flags back from the frame table
   cmd_type  cmd;
   flag_type flags;

   // Sequencer: scans frames one per cycle on allocate, walks the FIFO pointer
   // when free frames run out, and alternates read/check per frame on free.
   pfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .flags (flags),
      .cmd   (cmd)
   );

   // Frame table: used bits in flops, owner IDs in a single-port-write memory,
   // free count kept incrementally, result word registered on respond.
   pfa_datapath #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

// ----- design/pfa_ctrl.sv -----
`default_nettype none
module pfa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire pfa_pkg::flag_type flags,
   output pfa_pkg::cmd_type       cmd
);
   import pfa_pkg::*;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_REJECTED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (flags.is_free_req) begin
                  state_in = S_FREE_RD;
               end else if (flags.want_zero) begin
                  code_in  = ST_REJECTED;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_ALLOC_SCAN;
               end
            end
         end
         S_ALLOC_SCAN: begin
            if (flags.cur_free && flags.met_next) begin
               code_in  = ST_FREE_ALLOC;
               state_in = S_FINISH;
            end else if (flags.idx_last) begin
               code_in  = ST_FIFO_ALLOC;
               state_in = S_FIFO_WR;
            end
         end
         S_FIFO_WR: begin
            if (flags.rem_last) begin
               state_in = S_FINISH;
            end
         end
         S_FREE_RD: begin
            state_in = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (flags.idx_last) begin
               code_in  = (flags.any_writes || flags.owner_match) ? ST_FREED : ST_NOT_FOUND;
               state_in = S_FINISH;
            end else begin
               state_in = S_FREE_RD;
            end
         end
         S_FINISH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd               = '0;
      cmd.code          = code_ff;
      busy              = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            cmd.load = start;
         end
         S_ALLOC_SCAN: begin
            cmd.take    = flags.cur_free;
            cmd.idx_inc = !(flags.cur_free && flags.met_next) && !flags.idx_last;
         end
         S_FIFO_WR: begin
            cmd.fifo_write = 1'b1;
         end
         S_FREE_RD: begin
            cmd.take = 1'b0;
         end
         S_FREE_CHK: begin
            cmd.release_frame = flags.owner_match;
            cmd.idx_inc       = !flags.idx_last;
         end
         S_FINISH: begin
            cmd.respond = 1'b1;
         end
         default: begin
            cmd.respond = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- design/pfa_datapath.sv -----
`default_nettype none
module pfa_datapath #(
   parameter int NUM_FRAMES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pfa_pkg::req_word_type req_word,
   input  wire pfa_pkg::cmd_type      cmd,
   output pfa_pkg::flag_type          flags,
   output logic                       rsp_valid,
   output pfa_pkg::rsp_word_type      rsp_word
);
   import pfa_pkg::*;

   localparam int IW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int FCW = $clog2(NUM_FRAMES + 1);

   req_word_type          req_ff, req_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [IW-1:0]         fptr_ff, fptr_in;
   logic [3:0]            writes_ff, writes_in;
   logic [3:0]            rem_ff, rem_in;
   logic [FCW-1:0]        cnt_ff, cnt_in;
   logic [NUM_FRAMES-1:0] used_ff, used_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_ff, rsp_in;

   logic [7:0]            owner_mem [NUM_FRAMES];
   logic [7:0]            rd_owner_ff;
   logic                  mem_we;
   logic [IW-1:0]         mem_addr;
   logic [3:0]            writes_inc;
   logic                  cnt_over;

   assign writes_inc = (writes_ff == 4'd15) ? writes_ff : writes_ff + 4'd1;
   assign cnt_over   = ({{(32-FCW){1'b0}}, cnt_ff} > 32'd15);

   // owner table: written by allocation, read at the scan index
   assign mem_we   = cmd.take || cmd.fifo_write;
   assign mem_addr = cmd.take ? idx_ff : fptr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         owner_mem[mem_addr] <= req_ff.proc_id;
      end
      rd_owner_ff <= owner_mem[idx_ff];
   end

   always_comb begin
      flags.is_free_req = (req_word.req_type == REQ_FREE);
      flags.want_zero   = (req_word.pages_needed == 4'd0);
      flags.cur_free    = !used_ff[idx_ff];
      flags.met_next    = ({1'b0, writes_ff} + 5'd1) == {1'b0, req_ff.pages_needed};
      flags.idx_last    = (idx_ff == IW'(NUM_FRAMES - 1));
      flags.owner_match = used_ff[idx_ff] && (rd_owner_ff == req_ff.proc_id);
      flags.any_writes  = (writes_ff != 4'd0);
      flags.rem_last    = (rem_ff == 4'd1);
   end

   always_comb begin
      req_in       = req_ff;
      idx_in       = idx_ff;
      fptr_in      = fptr_ff;
      writes_in    = writes_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      used_in      = used_ff;
      rsp_valid_in = cmd.respond;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         req_in    = req_word;
         idx_in    = '0;
         writes_in = '0;
         rem_in    = req_word.pages_needed;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + IW'(1);
      end
      if (cmd.take) begin
         used_in[idx_ff] = 1'b1;
         cnt_in          = cnt_ff - FCW'(1);
         writes_in       = writes_inc;
      end
      if (cmd.fifo_write) begin
         used_in[fptr_ff] = 1'b1;
         if (!used_ff[fptr_ff]) begin
            cnt_in = cnt_ff - FCW'(1);
         end
         writes_in = writes_inc;
         rem_in    = rem_ff - 4'd1;
         fptr_in   = (fptr_ff == IW'(NUM_FRAMES - 1)) ? '0 : fptr_ff + IW'(1);
      end
      if (cmd.release_frame) begin
         used_in[idx_ff] = 1'b0;
         cnt_in          = cnt_ff + FCW'(1);
         writes_in       = writes_inc;
      end
      if (cmd.respond) begin
         rsp_in.status         = cmd.code;
         rsp_in.frames_changed = writes_ff;
         rsp_in.free_frames    = cnt_over ? 4'd15 : 4'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         cnt_ff       <= FCW'(NUM_FRAMES);
         fptr_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         cnt_ff       <= cnt_in;
         fptr_ff      <= fptr_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      writes_ff <= writes_in;
      rem_ff    <= rem_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire
